FILE: design/gtss_pkg.sv
// ----------------------------------------------------------------------------
// gtss_pkg: shared types and microcode for the Gaussian series block
// Register indexes, status codes, sequencer step codes and the control ROM.
// ----------------------------------------------------------------------------
package gtss_pkg;

  localparam int MAX_TERMS_DEF   = 255;
  localparam int X_FRAC_BITS_DEF = 13;

  localparam int SUM_W   = 64;
  localparam int X_W     = 16;
  localparam int TOL_W   = 32;
  localparam int TERMS_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // Term magnitude limit and sum limits
  localparam logic [63:0] MAG_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SUM_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SUM_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;
  localparam logic [7:0]  TERM_COUNT_RST = 8'd50;
  localparam logic [31:0] TOLERANCE_RST  = 32'd42950;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOP_MODE  = 2'd0,
    REG_TERM_COUNT = 2'd1,
    REG_TOLERANCE  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_CAP = 2'd1,
    ST_OVF = 2'd2
  } status_t;

  // Sequencer steps
  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_CHECK = 3'd1,
    S_MUL   = 3'd2,
    S_DIVLD = 3'd3,
    S_DIV   = 3'd4,
    S_UPD   = 3'd5,
    S_FIN   = 3'd6
  } step_t;

  // Datapath operation of a step
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_IDLE  = 3'd1,
    OP_CHECK = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIVLD = 3'd4,
    OP_DIV   = 3'd5,
    OP_UPD   = 3'd6,
    OP_FIN   = 3'd7
  } op_t;

  // Branch kind: fall through, repeat while loop count left, jump on test,
  // wait for test
  typedef enum logic [1:0] {
    BR_NEXT = 2'd0,
    BR_LOOP = 2'd1,
    BR_TEST = 2'd2,
    BR_WAIT = 2'd3
  } br_t;

  typedef enum logic [1:0] {
    LD_NONE = 2'd0,
    LD_MUL  = 2'd1,
    LD_DIV  = 2'd2
  } ld_t;

  typedef struct packed {
    op_t   op;
    br_t   br;
    ld_t   load;
    step_t nxt;
    step_t alt;
  } ucode_t;

  function automatic ucode_t ucode(input step_t s);
    ucode_t w;
    case (s)
      S_IDLE:  w = '{op: OP_IDLE,  br: BR_WAIT, load: LD_NONE, nxt: S_CHECK, alt: S_IDLE};
      S_CHECK: w = '{op: OP_CHECK, br: BR_TEST, load: LD_MUL,  nxt: S_MUL,   alt: S_FIN};
      S_MUL:   w = '{op: OP_MUL,   br: BR_LOOP, load: LD_NONE, nxt: S_DIVLD, alt: S_IDLE};
      S_DIVLD: w = '{op: OP_DIVLD, br: BR_NEXT, load: LD_DIV,  nxt: S_DIV,   alt: S_IDLE};
      S_DIV:   w = '{op: OP_DIV,   br: BR_LOOP, load: LD_NONE, nxt: S_UPD,   alt: S_IDLE};
      S_UPD:   w = '{op: OP_UPD,   br: BR_TEST, load: LD_NONE, nxt: S_CHECK, alt: S_FIN};
      S_FIN:   w = '{op: OP_FIN,   br: BR_WAIT, load: LD_NONE, nxt: S_IDLE,  alt: S_IDLE};
      default: w = '{op: OP_NOP,   br: BR_NEXT, load: LD_NONE, nxt: S_IDLE,  alt: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: design/gaussian_taylor_series_sum.sv
// ----------------------------------------------------------------------------
// gaussian_taylor_series_sum: Maclaurin series of exp(-x*x)
// Microcoded sequencer over a 16-bit-slice multiplier and an 8-bit-per-cycle
// divider by the term index; fixed or tolerance stop, saturating sum.
// ----------------------------------------------------------------------------
// Steps: after accept, each term runs a check, the multiply passes, a divide
//   load, 9 divide steps at X_FRAC_BITS 13 and an update; a final check or a
//   saturated term or sum ends the series and the result loads when free.
// Throughput: one item at a time; next accept in idle once the result loads.
// Reset: rst (synchronous) returns the sequencer to idle, drops any pending
//   result and restores stop_mode 0, term_count 50, tolerance 42950.
module gaussian_taylor_series_sum
  import gtss_pkg::*;
#(
  parameter int MAX_TERMS   = MAX_TERMS_DEF,
  parameter int X_FRAC_BITS = X_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [X_W-1:0]       x_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SUM_W-1:0]     sum_value,
  output logic [TERMS_W-1:0]   terms_used,
  output logic [1:0]           status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  // Widths derived from the parameters
  localparam int CW    = $clog2(MAX_TERMS + 1);    // term counter / divisor
  localparam int X2W   = 63 - 2 * X_FRAC_BITS;     // x*x aligned to Q.32
  localparam int X2SH  = 32 - 2 * X_FRAC_BITS;
  localparam int PRW   = 16 + X2W;                 // one slice product
  localparam int PW    = 63 + X2W;                 // full mag*x2 product
  localparam int SW    = PW - 32;                  // product >> 32
  localparam int DIV_STEPS = (SW + 7) / 8;         // 8 quotient bits per step
  localparam int QW    = DIV_STEPS * 8;
  localparam int MUL_PASSES = 5;                   // 4 slices + 1 drain
  localparam int LOOP_MAX = (DIV_STEPS > MUL_PASSES) ? DIV_STEPS - 1 : MUL_PASSES - 1;
  localparam int LW    = $clog2(LOOP_MAX + 1);

  // Configuration registers
  logic        stop_mode;
  logic [7:0]  term_count;
  logic [31:0] tolerance;

  // Sequencer
  step_t       step;
  step_t       step_next;
  ucode_t      uw;
  logic [LW-1:0] lcnt;
  logic        test;

  // Datapath registers
  logic [X2W-1:0]  x2;
  logic [63:0]     mag;
  logic            neg;
  logic [63:0]     sum;
  logic [CW-1:0]   added;
  logic [CW-1:0]   limit;
  status_t         st;
  logic [PRW-1:0]  prod;
  logic [PW-1:0]   acc;
  logic [QW-1:0]   div_reg;
  logic [CW-1:0]   rem;

  // Combinational helpers
  logic [15:0]     ax;
  logic [31:0]     axsq;
  logic [CW-1:0]   dvs;
  logic [CW-1:0]   rem_next;
  logic [CW:0]     r2;
  logic [7:0]      qbits;
  logic            stop_hit;
  logic            term_ovf;
  logic [63:0]     mag_new;
  logic            neg_new;
  logic [64:0]     s65;
  logic            sum_ovf;
  logic            upd_fail;
  logic            out_free;
  logic            in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = (step == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_mode  <= 1'b0;
      term_count <= TERM_COUNT_RST;
      tolerance  <= TOLERANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STOP_MODE:  stop_mode  <= cfg_data[0];
        REG_TERM_COUNT: term_count <= cfg_data[7:0];
        REG_TOLERANCE:  tolerance  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Fetch the control word of the current step
  always_comb begin
    uw = ucode(step);
  end

  // |x| and x*x for the load step
  always_comb begin
    ax   = x_value[X_W-1] ? 16'(-x_value) : x_value;
    axsq = 32'(ax) * 32'(ax);
  end

  // Stop test ahead of each term: tolerance met or term budget used up
  assign stop_hit = (stop_mode && (mag <= {32'd0, tolerance})) || (added >= limit);

  // Divisor is the index of the term being formed
  assign dvs = added + CW'(1);

  // Eight restoring division steps per cycle on the narrow remainder
  always_comb begin
    rem_next = rem;
    qbits    = '0;
    r2       = '0;
    for (int b = 0; b < 8; b++) begin
      r2 = {rem_next, div_reg[QW-1-b]};
      if (r2 >= {1'b0, dvs}) begin
        r2 = r2 - {1'b0, dvs};
        qbits[7-b] = 1'b1;
      end
      rem_next = r2[CW-1:0];
    end
  end

  // Term update: saturate the magnitude, flip the sign, saturating accumulate
  always_comb begin
    term_ovf = |div_reg[QW-1:63];
    mag_new  = term_ovf ? MAG_MAX : {1'b0, div_reg[62:0]};
    neg_new  = !neg;
    if (neg_new) begin
      s65 = {sum[63], sum} - {1'b0, mag_new};
    end else begin
      s65 = {sum[63], sum} + {1'b0, mag_new};
    end
    sum_ovf  = (s65[64] != s65[63]);
    upd_fail = term_ovf || sum_ovf;
  end

  // Branch condition for the current step
  always_comb begin
    case (uw.op)
      OP_IDLE:  test = in_valid;
      OP_CHECK: test = stop_hit;
      OP_UPD:   test = upd_fail;
      OP_FIN:   test = out_free;
      default:  test = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    case (uw.br)
      BR_NEXT: step_next = uw.nxt;
      BR_LOOP: step_next = (lcnt != '0) ? step : uw.nxt;
      BR_TEST: step_next = test ? uw.alt : uw.nxt;
      BR_WAIT: step_next = test ? uw.nxt : step;
      default: step_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
      lcnt <= '0;
    end else begin
      step <= step_next;
      case (uw.load)
        LD_MUL:  lcnt <= LW'(MUL_PASSES - 1);
        LD_DIV:  lcnt <= LW'(DIV_STEPS - 1);
        default: begin
          if (uw.br == BR_LOOP && lcnt != '0) begin
            lcnt <= lcnt - LW'(1);
          end
        end
      endcase
    end
  end

  // Datapath, driven by the control word
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_OK;
    end else begin
      case (uw.op)
        OP_IDLE: begin
          if (in_fire) begin
            x2    <= X2W'(64'(axsq) << X2SH);
            mag   <= ONE_Q32;
            sum   <= ONE_Q32;
            neg   <= 1'b0;
            added <= '0;
            if (stop_mode) begin
              limit <= CW'(MAX_TERMS);
              st    <= ST_OK;
            end else if (int'(term_count) > MAX_TERMS) begin
              limit <= CW'(MAX_TERMS);
              st    <= ST_CAP;
            end else begin
              limit <= CW'(term_count);
              st    <= ST_OK;
            end
          end
        end
        OP_CHECK: begin
          // Clear the multiply accumulator; flag the cap in tolerance mode
          acc  <= '0;
          prod <= '0;
          if (stop_hit && stop_mode && !(mag <= {32'd0, tolerance})) begin
            st <= ST_CAP;
          end
        end
        OP_MUL: begin
          // Top slice first; shifted-out slices feed zeros to the drain pass
          prod <= PRW'(mag[63:48]) * PRW'(x2);
          mag  <= {mag[47:0], 16'd0};
          acc  <= (acc << 16) + PW'(prod);
        end
        OP_DIVLD: begin
          div_reg <= QW'(acc[PW-1:32]);
          rem     <= '0;
        end
        OP_DIV: begin
          div_reg <= {div_reg[QW-9:0], qbits};
          rem     <= rem_next;
        end
        OP_UPD: begin
          mag   <= mag_new;
          neg   <= neg_new;
          added <= added + CW'(1);
          if (sum_ovf) begin
            sum <= neg_new ? SUM_MIN : SUM_MAX;
          end else begin
            sum <= s65[63:0];
          end
          if (upd_fail) begin
            st <= ST_OVF;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: load on finish when free, hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.op == OP_FIN && out_free) begin
      out_valid  <= 1'b1;
      sum_value  <= sum;
      terms_used <= (int'(added) > 255) ? 8'hFF : 8'(added);
      status     <= st;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Checks on the sequencer and datapath
  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> step == S_CHECK)
    else $error("accepted item did not start a term pass");

  a_mul_drained: assert property (@(posedge clk) disable iff (rst)
    step == S_DIVLD |-> prod == '0 && mag == '0)
    else $error("multiply slices not fully consumed");

  a_upd_in_budget: assert property (@(posedge clk) disable iff (rst)
    step == S_UPD |-> added < limit)
    else $error("term formed beyond its budget");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_CAP || status == ST_OVF))
    else $error("bad status code on result");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (step == S_MUL || step == S_DIV) |-> !in_ready)
    else $error("input ready while a term is in progress");

endmodule
